// ===== hw/rtl/gmt_pkg.sv =====
// ----------------------------------------------------------------------------
// gmt_pkg
// Shared types and codes for the gossip membership table.
// ----------------------------------------------------------------------------
package gmt_pkg;

  localparam int MaxMembers = 16;
  localparam int IdxW = $clog2(MaxMembers);
  localparam int CntW = $clog2(MaxMembers + 1);
  localparam int ResultCap = 16;

  localparam logic [2:0] CMD_JOIN_REQ = 3'd0;
  localparam logic [2:0] CMD_JOIN_REP = 3'd1;
  localparam logic [2:0] CMD_PING = 3'd2;
  localparam logic [2:0] CMD_GOSSIP = 3'd3;
  localparam logic [2:0] CMD_TICK = 3'd4;

  localparam logic [2:0] KIND_DONE = 3'd0;
  localparam logic [2:0] KIND_JOIN_REPLY = 3'd1;
  localparam logic [2:0] KIND_DROPPED = 3'd2;
  localparam logic [2:0] KIND_PING = 3'd3;
  localparam logic [2:0] KIND_TICK_EMPTY = 3'd4;
  localparam logic [2:0] KIND_NOT_IN_GROUP = 3'd5;

  localparam logic [1:0] REG_SELF_ID = 2'd0;
  localparam logic [1:0] REG_SELF_PORT = 2'd1;
  localparam logic [1:0] REG_TIMEOUT = 2'd2;
  localparam logic [1:0] REG_INTRODUCER = 2'd3;

  typedef struct packed {
    logic [15:0] id;
    logic [15:0] port;
    logic [31:0] heartbeat;
    logic [31:0] stamp;
  } entry_t;

  // memory port bundle from the controller
  typedef struct packed {
    logic            rd_en;
    logic [IdxW-1:0] rd_addr;
    logic            wr_en;
    logic [IdxW-1:0] wr_addr;
    entry_t          wr_data;
  } mem_req_t;

endpackage

// ===== hw/rtl/gmt_table_mem.sv =====
// ----------------------------------------------------------------------------
// gmt_table_mem
// Membership entry store: one write port, one registered read port.
// ----------------------------------------------------------------------------
module gmt_table_mem
  import gmt_pkg::*;
(
  input  logic     clk,
  input  mem_req_t req,
  output entry_t   rd_data
);

  entry_t mem [MaxMembers];

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      rd_data <= mem[req.rd_addr];
    end
  end

endmodule

// ===== hw/rtl/gossip_membership_table_unit.sv =====
// ----------------------------------------------------------------------------
// gossip_membership_table_unit
// Gossip heartbeat membership table: lookup, insert, expiry and ping fan-out.
// ----------------------------------------------------------------------------
// Channel   Dir  Handshake           Words
// command   in   start & !busy       cmd, now, member_*
// config    in   cfg_we              cfg_index, cfg_data
// result    out  strobe (no stall)   kind, dest_*, entry_*, last
//
// One memory read per cycle sets the rate. Lookup walks the table one entry a
// cycle. A tick walks twice (compact, then ping), emitting one result a cycle.
// rst clears count, group flags and config (timeout resets to 20); table contents are never cleared.
// busy stays high until the last result word has been strobed.
// ----------------------------------------------------------------------------
module gossip_membership_table_unit
  import gmt_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  cmd,
  input  logic [31:0] now,
  input  logic [15:0] member_id,
  input  logic [15:0] member_port,
  input  logic [31:0] member_heartbeat,
  input  logic [31:0] member_timestamp,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  output logic        strobe,
  output logic [2:0]  kind,
  output logic [15:0] dest_id,
  output logic [15:0] dest_port,
  output logic [31:0] entry_heartbeat,
  output logic [31:0] entry_timestamp,
  output logic        last
);

  typedef enum logic [3:0] {
    S_IDLE, S_SEARCH, S_DECIDE, S_EMIT2, S_COMPACT, S_PING, S_FINISH
  } state_t;

  state_t      state;
  logic [15:0] self_id, self_port, remove_timeout;
  logic        is_introducer, joined;
  logic [CntW-1:0] member_count;

  // latched command
  logic [2:0]  c_cmd;
  logic [31:0] c_now, c_hb, c_ts;
  logic [15:0] c_id, c_port;

  logic [CntW-1:0] rd_ptr;      // next entry to read
  logic [CntW-1:0] wr_ptr;      // compaction write pointer
  logic            rd_pend;     // read data valid this cycle
  logic [IdxW-1:0] pend_idx;
  logic            found;
  logic [IdxW-1:0] found_idx;
  entry_t          found_ent;
  logic [CntW-1:0] emitted;

  mem_req_t req;
  entry_t   rd_data;

  gmt_table_mem u_mem (.clk(clk), .req(req), .rd_data(rd_data));

  wire in_group = joined | is_introducer;
  wire [31:0] rd_age = c_now - rd_data.stamp;
  wire        rd_expired = rd_age >= {16'd0, remove_timeout};
  wire        rd_match = rd_data.id == c_id && rd_data.port == c_port;
  wire        full = member_count == CntW'(MaxMembers);
  wire [31:0] gossip_age = c_now - c_ts;

  assign busy = state != S_IDLE;

  // memory request: reads driven by rd_ptr in walking states, writes by state
  always_comb begin
    req = '0;
    req.rd_addr = rd_ptr[IdxW-1:0];
    req.rd_en = ((state == S_SEARCH || state == S_COMPACT || state == S_PING) &&
                 rd_ptr < member_count);
    case (state)
      S_DECIDE: begin
        if (found) begin
          req.wr_addr = found_idx;
          req.wr_data = found_ent;
          if (c_cmd == CMD_PING) begin
            req.wr_en = 1'b1;
            req.wr_data.heartbeat = found_ent.heartbeat + 32'd1;
            req.wr_data.stamp = c_now;
          end else if (c_cmd == CMD_GOSSIP && c_hb > found_ent.heartbeat) begin
            req.wr_en = 1'b1;
            req.wr_data.heartbeat = c_hb;
            req.wr_data.stamp = c_now;
          end
        end else begin
          req.wr_addr = member_count[IdxW-1:0];
          req.wr_data.id = c_id;
          req.wr_data.port = c_port;
          if (c_cmd == CMD_GOSSIP) begin
            req.wr_data.heartbeat = c_hb;
            req.wr_data.stamp = c_ts;
            req.wr_en = !full && !(c_id == self_id && c_port == self_port) &&
                        gossip_age < {16'd0, remove_timeout};
          end else begin
            req.wr_data.heartbeat = 32'd1;
            req.wr_data.stamp = c_now;
            req.wr_en = !full && (c_cmd == CMD_JOIN_REQ || c_cmd == CMD_JOIN_REP ||
                                  c_cmd == CMD_PING);
          end
        end
      end
      S_COMPACT: begin
        req.wr_en = rd_pend && !rd_expired;
        req.wr_addr = wr_ptr[IdxW-1:0];
        req.wr_data = rd_data;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      self_id <= '0;
      self_port <= '0;
      remove_timeout <= 16'd20;
      is_introducer <= 1'b0;
      joined <= 1'b0;
      member_count <= '0;
      strobe <= 1'b0;
      rd_pend <= 1'b0;
    end else begin
      strobe <= 1'b0;
      if (cfg_we) begin
        case (cfg_index)
          REG_SELF_ID:    self_id <= cfg_data;
          REG_SELF_PORT:  self_port <= cfg_data;
          REG_TIMEOUT:    remove_timeout <= cfg_data;
          REG_INTRODUCER: is_introducer <= cfg_data[0];
          default: ;
        endcase
      end
      rd_pend <= req.rd_en;
      pend_idx <= rd_ptr[IdxW-1:0];
      if (req.rd_en) rd_ptr <= rd_ptr + 1'b1;
      case (state)
        S_IDLE: begin
          if (start) begin
            c_cmd <= cmd; c_now <= now; c_id <= member_id; c_port <= member_port;
            c_hb <= member_heartbeat; c_ts <= member_timestamp;
            rd_ptr <= '0; wr_ptr <= '0; found <= 1'b0; emitted <= '0;
            if (cmd == CMD_TICK) begin
              state <= in_group ? S_COMPACT : S_FINISH;
            end else if (cmd == CMD_JOIN_REQ || cmd == CMD_JOIN_REP ||
                         cmd == CMD_PING || cmd == CMD_GOSSIP) begin
              state <= S_SEARCH;
            end else begin
              state <= S_FINISH;
            end
          end
        end
        S_SEARCH: begin
          if (rd_pend && rd_match && !found) begin
            found <= 1'b1;
            found_idx <= pend_idx;
            found_ent <= rd_data;
          end
          if (!req.rd_en && !rd_pend) state <= S_DECIDE;
        end
        S_DECIDE: begin
          if (!found && req.wr_en) member_count <= member_count + 1'b1;
          if (c_cmd == CMD_JOIN_REP) joined <= 1'b1;
          kind <= KIND_DONE; dest_id <= '0; dest_port <= '0;
          entry_heartbeat <= '0; entry_timestamp <= '0; last <= 1'b1;
          if (!found && full &&
              (c_cmd != CMD_GOSSIP || (!(c_id == self_id && c_port == self_port) &&
                                        gossip_age < {16'd0, remove_timeout}))) begin
            strobe <= 1'b1;
            kind <= KIND_DROPPED; dest_id <= c_id; dest_port <= c_port;
            entry_heartbeat <= (c_cmd == CMD_GOSSIP) ? c_hb : 32'd1;
            entry_timestamp <= (c_cmd == CMD_GOSSIP) ? c_ts : c_now;
            last <= c_cmd != CMD_JOIN_REQ;
            state <= (c_cmd == CMD_JOIN_REQ) ? S_EMIT2 : S_IDLE;
          end else if (c_cmd == CMD_JOIN_REQ) begin
            strobe <= 1'b1;
            kind <= KIND_JOIN_REPLY; dest_id <= c_id; dest_port <= c_port;
            state <= S_IDLE;
          end else begin
            strobe <= 1'b1;
            state <= S_IDLE;
          end
        end
        S_EMIT2: begin
          strobe <= 1'b1;
          kind <= KIND_JOIN_REPLY; dest_id <= c_id; dest_port <= c_port;
          entry_heartbeat <= '0; entry_timestamp <= '0; last <= 1'b1;
          state <= S_IDLE;
        end
        S_COMPACT: begin
          if (req.wr_en) wr_ptr <= wr_ptr + 1'b1;
          if (!req.rd_en && !rd_pend) begin
            member_count <= wr_ptr;
            rd_ptr <= '0;
            if (wr_ptr == '0) begin
              strobe <= 1'b1;
              kind <= KIND_TICK_EMPTY; dest_id <= '0; dest_port <= '0;
              entry_heartbeat <= '0; entry_timestamp <= '0; last <= 1'b1;
              state <= S_IDLE;
            end else begin
              state <= S_PING;
            end
          end
        end
        S_PING: begin
          if (rd_pend) begin
            strobe <= 1'b1;
            kind <= KIND_PING; dest_id <= rd_data.id; dest_port <= rd_data.port;
            entry_heartbeat <= rd_data.heartbeat; entry_timestamp <= rd_data.stamp;
            emitted <= emitted + 1'b1;
            last <= !req.rd_en || emitted == CntW'(ResultCap - 1);
            if (!req.rd_en || emitted == CntW'(ResultCap - 1)) state <= S_IDLE;
          end
        end
        S_FINISH: begin
          strobe <= 1'b1;
          kind <= (c_cmd == CMD_TICK) ? KIND_NOT_IN_GROUP : KIND_DONE;
          dest_id <= '0; dest_port <= '0;
          entry_heartbeat <= '0; entry_timestamp <= '0; last <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // table never exceeds capacity
  assert property (@(posedge clk) disable iff (rst)
    member_count <= CntW'(MaxMembers)) else $error("member count overflow");
  // a command is never accepted while results are still pending
  assert property (@(posedge clk) disable iff (rst)
    strobe && !last |-> busy) else $error("busy dropped before last word");
  // compaction never writes ahead of the read pointer
  assert property (@(posedge clk) disable iff (rst)
    state == S_COMPACT |-> wr_ptr <= rd_ptr) else $error("compaction overran");

endmodule
